// File: sv/xmrx_pkg.sv
`default_nettype none
package xmrx_pkg;

	localparam int DATA_BYTES_DEF = 5;
	// output queue depth; power of two so pointers wrap on their own
	localparam int OUT_DEPTH = 4;

	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] NAK_BYTE = 8'h15;
	localparam logic [7:0] PAD_RESET = 8'h03;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ACK = 2'd1;
	localparam logic [1:0] KIND_NAK = 2'd2;

	// register word index (paddr[2])
	localparam logic REG_PAD = 1'b0;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [7:0] block_num;
		logic transfer_done;
		logic last;
	} res_t;

endpackage
`default_nettype wire

// File: sv/xmrx_parser.sv
`default_nettype none
module xmrx_parser import xmrx_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF,
	localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic opcode,
	input wire logic [7:0] rx_byte,
	output logic push,
	output res_t push_res,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0] wr_data,
	output logic burst_start,
	output logic [7:0] burst_blk
);

	localparam int IDX_W = $clog2(DATA_BYTES + 3);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_COLLECT = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	logic [1:0] phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0] blk_q, blk_d;
	logic [7:0] cmp_q, cmp_d;
	logic [7:0] sum_q, sum_d;
	logic hdr_ok;

	assign hdr_ok = (~blk_q == cmp_q);
	assign wr_addr = AW'(idx_q - IDX_W'(2));
	assign wr_data = rx_byte;
	assign burst_blk = blk_q;

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		blk_d = blk_q;
		cmp_d = cmp_q;
		sum_d = sum_q;
		push = 1'b0;
		push_res = '0;
		push_res.last = 1'b1;
		wr_en = 1'b0;
		burst_start = 1'b0;
		if (in_fire) begin
			if (opcode) begin
				phase_d = PH_HUNT;
				idx_d = '0;
				blk_d = '0;
				cmp_d = '0;
				sum_d = '0;
				push = 1'b1;
				push_res.kind = KIND_NAK;
				push_res.value = NAK_BYTE;
			end else begin
				case (phase_q)
					PH_COLLECT: begin
						if (idx_q == IDX_W'(0)) begin
							blk_d = rx_byte;
							idx_d = IDX_W'(1);
						end else if (idx_q == IDX_W'(1)) begin
							cmp_d = rx_byte;
							idx_d = IDX_W'(2);
						end else if (idx_q < IDX_W'(DATA_BYTES + 2)) begin
							wr_en = 1'b1;
							sum_d = sum_q + rx_byte;
							idx_d = idx_q + IDX_W'(1);
						end else begin
							// checksum byte: judge the block
							if (!hdr_ok || sum_q != rx_byte) begin
								push = 1'b1;
								push_res.kind = KIND_NAK;
								push_res.value = NAK_BYTE;
								push_res.block_num = blk_q;
							end else begin
								burst_start = 1'b1;
							end
							phase_d = PH_HUNT;
							idx_d = '0;
							blk_d = '0;
							cmp_d = '0;
							sum_d = '0;
						end
					end
					PH_DONE: begin
					end
					default: begin
						phase_d = PH_HUNT;
						if (rx_byte == EOT_BYTE) begin
							push = 1'b1;
							push_res.kind = KIND_ACK;
							push_res.value = ACK_BYTE;
							push_res.transfer_done = 1'b1;
							phase_d = PH_DONE;
						end else if (rx_byte == SOH_BYTE) begin
							idx_d = '0;
							blk_d = '0;
							cmp_d = '0;
							sum_d = '0;
							phase_d = PH_COLLECT;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q <= '0;
			blk_q <= '0;
			cmp_q <= '0;
			sum_q <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			blk_q <= blk_d;
			cmp_q <= cmp_d;
			sum_q <= sum_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/xmrx_emitter.sv
`default_nettype none
module xmrx_emitter import xmrx_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF,
	localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1,
	localparam int CW = $clog2(OUT_DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [7:0] wr_data,
	input wire logic burst_start,
	input wire logic [7:0] burst_blk,
	input wire logic [7:0] pad_byte,
	input wire logic [CW-1:0] fifo_count,
	output logic push,
	output res_t push_res,
	output logic busy
);

	logic [7:0] mem [DATA_BYTES];
	logic act_q;
	logic ack_q;
	logic [AW-1:0] rd_idx_q;
	logic [7:0] blk_q;
	logic rd_valid_s1;
	logic [7:0] rd_data_s1;
	logic [CW:0] fill;
	logic issue;
	logic last_rd;
	logic push_data;
	logic push_ack;

	// queue entries already claimed: stored ones plus the one landing this edge
	assign fill = {1'b0, fifo_count} + (CW + 1)'(rd_valid_s1);
	assign issue = act_q && (fill <= (CW + 1)'(OUT_DEPTH - 2));
	assign last_rd = (rd_idx_q == AW'(DATA_BYTES - 1));
	assign push_data = rd_valid_s1 && (rd_data_s1 != pad_byte);
	assign push_ack = ack_q && !rd_valid_s1 && (fifo_count != CW'(OUT_DEPTH));
	assign push = push_data || push_ack;
	assign busy = act_q || ack_q || rd_valid_s1;

	always_comb begin
		push_res = '0;
		push_res.block_num = blk_q;
		if (push_data) begin
			push_res.kind = KIND_DATA;
			push_res.value = rd_data_s1;
		end else begin
			push_res.kind = KIND_ACK;
			push_res.value = ACK_BYTE;
			push_res.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (issue)
			rd_data_s1 <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ack_q <= 1'b0;
			rd_idx_q <= '0;
			blk_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (burst_start) begin
				act_q <= 1'b1;
				rd_idx_q <= '0;
				blk_q <= burst_blk;
			end else if (issue) begin
				if (last_rd) begin
					act_q <= 1'b0;
					ack_q <= 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
			if (push_ack)
				ack_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: sv/xmrx_out_fifo.sv
`default_nettype none
module xmrx_out_fifo import xmrx_pkg::*; #(
	localparam int PW = $clog2(OUT_DEPTH),
	localparam int CW = $clog2(OUT_DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire res_t push_res,
	input wire logic pop,
	output res_t head,
	output logic [CW-1:0] count
);

	res_t buf_q [OUT_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head = buf_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

// File: sv/block_receiver_with_checksum_core.sv
// Block receiver with 8-bit additive checksum.
// Input stream: one transfer per received byte (tuser = 0) or a start command
// (tuser = 1). Output stream: tuser = kind (data, ACK, NAK), tdata carries the
// byte value, block number and end-of-transfer flag, tlast marks the final
// result caused by one input transfer.
// A header, data or single-answer byte is taken every cycle while the queue
// has room; its answer (NAK, EOT ACK, start NAK) enters the output queue in
// the cycle of acceptance. On a good block the checksum byte starts a readout
// of the data store, one result per cycle while the queue has room (one store
// read per cycle, each registered before its push, pad bytes dropped), then
// the ACK. Input tready is low during that readout.
// A 4-entry output queue decouples the sides: when the downstream stalls,
// input is still taken until the queue is full.
// Reset clears the receive state to hunting, empties the queue and sets the
// pad register to 0x03. The data store is not cleared; every entry is
// written before a block is judged.
// APB: one register, pad_byte, at offset 0; pready is always high.
`default_nettype none
module block_receiver_with_checksum_core import xmrx_pkg::*; #(
	parameter int DATA_BYTES = DATA_BYTES_DEF,
	localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1,
	localparam int CW = $clog2(OUT_DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	input wire logic [0:0] s_axis_tuser,   // [0] opcode
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata,      // [7:0] value, [15:8] block_num, [16] transfer_done
	output logic [1:0] m_axis_tuser,       // [1:0] kind
	output logic m_axis_tlast,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [7:0] pad_q;
	logic in_fire;
	logic p_push, e_push, q_push;
	res_t p_res, e_res, q_res, head;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic burst_start;
	logic [7:0] burst_blk;
	logic busy;
	logic [CW-1:0] count;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PAD) ? {24'd0, pad_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pad_q <= PAD_RESET;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_PAD)
			pad_q <= pwdata[7:0];
	end

	assign s_axis_tready = !busy && (count != CW'(OUT_DEPTH));
	assign in_fire = s_axis_tvalid && s_axis_tready;

	xmrx_parser #(.DATA_BYTES(DATA_BYTES)) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.opcode(s_axis_tuser[0]),
		.rx_byte(s_axis_tdata),
		.push(p_push),
		.push_res(p_res),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.burst_start(burst_start),
		.burst_blk(burst_blk)
	);

	xmrx_emitter #(.DATA_BYTES(DATA_BYTES)) u_emitter (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.burst_start(burst_start),
		.burst_blk(burst_blk),
		.pad_byte(pad_q),
		.fifo_count(count),
		.push(e_push),
		.push_res(e_res),
		.busy(busy)
	);

	// parser and emitter never push in the same cycle: input is held off during readout
	assign q_push = p_push || e_push;
	assign q_res = p_push ? p_res : e_res;

	xmrx_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_res(q_res),
		.pop(m_axis_tvalid && m_axis_tready),
		.head(head),
		.count(count)
	);

	assign m_axis_tvalid = (count != CW'(0));
	assign m_axis_tdata = {7'd0, head.transfer_done, head.block_num, head.value};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

// File: tb/block_receiver_with_checksum_core_test.sv
`default_nettype none
module block_receiver_with_checksum_core_test;
	import xmrx_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DB = DATA_BYTES_DEF;
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_START = 1'b1;
	localparam logic [2:0] PAD_ADDR = {REG_PAD, 2'b00};
	// longest readout of a good block plus margin
	localparam int SETTLE_CYCLES = DB + 8;

	typedef enum logic [1:0] {RX_HUNT, RX_COLLECT, RX_DONE} rx_phase_t;
	typedef logic [7:0] block_data_t [DB];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;   // [7:0] rx_byte
	logic [0:0] s_axis_tuser = '0;   // [0] opcode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // [7:0] value, [15:8] block_num, [16] transfer_done
	logic [1:0] m_axis_tuser;        // [1:0] kind
	logic m_axis_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// receiver model state
	rx_phase_t rx_phase = RX_HUNT;
	logic [7:0] rx_pos = '0;
	logic [7:0] rx_blk = '0;
	logic [7:0] rx_cmpl = '0;
	logic [7:0] rx_sum = '0;
	logic [7:0] rx_data [DB];
	logic [7:0] pad_cfg = PAD_RESET;

	res_t expected_answers[$];
	int errors = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;

	block_receiver_with_checksum_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < 19);
	endfunction

	function automatic res_t answer(input logic [1:0] kind, input logic [7:0] value,
			input logic [7:0] blk, input logic done);
		res_t r;
		r.kind = kind;
		r.value = value;
		r.block_num = blk;
		r.transfer_done = done;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void clear_block();
		rx_pos = '0;
		rx_blk = '0;
		rx_cmpl = '0;
		rx_sum = '0;
	endfunction

	// expected answers for one accepted transfer
	function automatic void predict_answers(input logic op, input logic [7:0] b);
		res_t outs[$];
		if (op == OP_START) begin
			outs = {outs, answer(KIND_NAK, NAK_BYTE, 8'h00, 1'b0)};
			rx_phase = RX_HUNT;
			clear_block();
		end else begin
			case (rx_phase)
				RX_COLLECT: begin
					if (rx_pos == 8'd0) begin
						rx_blk = b;
						rx_pos = 8'd1;
					end else if (rx_pos == 8'd1) begin
						rx_cmpl = b;
						rx_pos = 8'd2;
					end else if (rx_pos < 2 + DB) begin
						rx_data[rx_pos - 8'd2] = b;
						rx_sum = rx_sum + b;
						rx_pos = rx_pos + 8'd1;
					end else begin
						// checksum byte: judge the block
						if (rx_cmpl != ~rx_blk || rx_sum != b) begin
							outs = {outs, answer(KIND_NAK, NAK_BYTE, rx_blk, 1'b0)};
						end else begin
							foreach (rx_data[i])
								if (rx_data[i] != pad_cfg)
									outs = {outs,
										answer(KIND_DATA, rx_data[i], rx_blk, 1'b0)};
							outs = {outs, answer(KIND_ACK, ACK_BYTE, rx_blk, 1'b0)};
						end
						rx_phase = RX_HUNT;
						clear_block();
					end
				end
				RX_DONE: begin
				end
				default: begin
					rx_phase = RX_HUNT;
					if (b == EOT_BYTE) begin
						outs = {outs, answer(KIND_ACK, ACK_BYTE, 8'h00, 1'b1)};
						rx_phase = RX_DONE;
					end else if (b == SOH_BYTE) begin
						clear_block();
						rx_phase = RX_COLLECT;
					end
				end
			endcase
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			expected_answers = {expected_answers, outs[i]};
	endfunction

	function automatic logic [7:0] sum_of(input block_data_t d);
		logic [7:0] s;
		s = '0;
		foreach (d[i])
			s = s + d[i];
		return s;
	endfunction

	// valid stays high between back-to-back transfers; lowered only on idle
	task automatic send_byte(input logic op, input logic [7:0] b);
		while (idle_now()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_answers(op, b);
		items_sent++;
	endtask

	task automatic send_block(input logic [7:0] blk, input logic [7:0] cmpl,
			input block_data_t d, input logic [7:0] chk);
		send_byte(OP_BYTE, SOH_BYTE);
		send_byte(OP_BYTE, blk);
		send_byte(OP_BYTE, cmpl);
		foreach (d[i])
			send_byte(OP_BYTE, d[i]);
		send_byte(OP_BYTE, chk);
	endtask

	// hold off input until every answer is out and the core is idle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_pad();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PAD_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'h0, pad_cfg})
			report_mismatch("pad_byte readback", prdata, {24'h0, pad_cfg});
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pad(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PAD_ADDR;
		pwdata <= {24'h0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pad_cfg = v;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		read_pad();
	endtask

	always @(posedge clk) begin : out_side
		res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("result with nothing expected",
					{5'h0, m_axis_tlast, m_axis_tuser, m_axis_tdata}, 32'h0);
			end else begin
				e = expected_answers.pop_front();
				if (m_axis_tuser !== e.kind)
					report_mismatch("kind", m_axis_tuser, e.kind);
				if (m_axis_tdata[7:0] !== e.value)
					report_mismatch("value", m_axis_tdata[7:0], e.value);
				if (m_axis_tdata[15:8] !== e.block_num)
					report_mismatch("block_num", m_axis_tdata[15:8], e.block_num);
				if (m_axis_tdata[16] !== e.transfer_done)
					report_mismatch("transfer_done", m_axis_tdata[16], e.transfer_done);
				if (m_axis_tlast !== e.last)
					report_mismatch("last", m_axis_tlast, e.last);
			end
		end
		m_axis_tready <= !idle_now();
	end

	task automatic test_reset_state();
		read_pad();
		send_byte(OP_BYTE, 8'h00);
		send_byte(OP_BYTE, 8'hff);
		send_byte(OP_START, 8'h01);
	endtask

	task automatic test_block_judging();
		block_data_t d;
		// pad, start byte and EOT inside data, extremes of the byte range
		d = '{PAD_RESET, SOH_BYTE, EOT_BYTE, 8'hff, 8'h00};
		send_block(8'hff, 8'h00, d, sum_of(d));
		d = '{8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55};
		send_block(8'h5a, 8'h5a, d, sum_of(d));          // bad complement
		send_block(8'h00, 8'hff, d, sum_of(d) + 8'h01);  // bad checksum
		// start command mid-block drops the partial block
		send_byte(OP_BYTE, SOH_BYTE);
		send_byte(OP_BYTE, 8'h07);
		send_byte(OP_BYTE, 8'hf8);
		send_byte(OP_START, 8'h00);
	endtask

	task automatic test_end_of_transfer();
		send_byte(OP_BYTE, EOT_BYTE);
		send_byte(OP_BYTE, SOH_BYTE);   // ignored after the end
		send_byte(OP_BYTE, EOT_BYTE);
		send_byte(OP_START, 8'hff);
	endtask

	task automatic test_pad_register();
		block_data_t d;
		logic [7:0] vals [3];
		vals = '{8'h00, 8'hff, 8'($urandom)};
		foreach (vals[k]) begin
			drain();
			set_pad(vals[k]);
			d = '{vals[k], 8'h00, 8'hff, vals[k], 8'($urandom)};
			send_block(8'($urandom), 8'h00, d, 8'h00);
			d[4] = vals[k];
			send_block(8'h33, 8'hcc, d, sum_of(d));
		end
		d = '{vals[2], vals[2], vals[2], vals[2], vals[2]};
		send_block(8'h01, 8'hfe, d, sum_of(d));  // every byte dropped, only ACK
	endtask

	task automatic test_random_traffic();
		block_data_t d;
		logic [7:0] blk;
		int start_count;
		int r;
		int cut;
		start_count = items_sent;
		while (items_sent - start_count < 60) begin
			no_idle = (items_sent - start_count) inside {[15:45]};
			r = $urandom_range(99);
			if (r < 70) begin
				blk = 8'($urandom);
				foreach (d[i])
					d[i] = ($urandom_range(3) == 0) ? pad_cfg : 8'($urandom);
				if ($urandom_range(99) < 8) begin
					cut = $urandom_range(2 + DB);
					send_byte(OP_BYTE, SOH_BYTE);
					for (int i = 0; i < cut; i++)
						send_byte(OP_BYTE, (i == 0) ? blk : (i == 1) ? ~blk : d[i - 2]);
					send_byte(OP_START, 8'($urandom));
				end else begin
					send_block(blk, ($urandom_range(99) < 90) ? ~blk : 8'($urandom), d,
						($urandom_range(99) < 85) ? sum_of(d) : 8'($urandom));
				end
			end else if (r < 80) begin
				send_byte(OP_BYTE, 8'($urandom));
			end else if (r < 87) begin
				send_byte(OP_START, 8'($urandom));
			end else if (r < 93) begin
				send_byte(OP_BYTE, EOT_BYTE);
				send_byte(OP_BYTE, 8'($urandom));
				send_byte(OP_START, 8'($urandom));
			end else begin
				drain();
				if (r < 97)
					set_pad(($urandom_range(3) == 0) ? PAD_RESET : 8'($urandom));
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_block_judging();
		test_end_of_transfer();
		test_pad_register();
		test_random_traffic();
		drain();
		if (expected_answers.size() != 0)
			report_mismatch("results never delivered", expected_answers.size(), 0);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
